/* design/i2c_master_transfer_defines.svh */
// Assertion helpers for the I2C master transfer block.
// Both macros sample on clk and are quiet while rst_n is low.
`ifndef I2C_MASTER_TRANSFER_DEFINES_SVH
`define I2C_MASTER_TRANSFER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that a property holds at every rising clock edge.
`define I2CM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("i2c master transfer: property failed");

// Check that a condition never occurs.
`define I2CM_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("i2c master transfer: forbidden condition seen");

`else

`define I2CM_ASSERT(label, prop)
`define I2CM_NEVER(label, cond)

`endif

`endif

/* design/i2cm_pkg.sv */
`timescale 1ns / 1ps

package i2cm_pkg;

    // Command codes carried in the func field
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_PUSH  = 2'd1;
    localparam logic [1:0] FUNC_BEGIN = 2'd2;

    // Transfer status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NACK     = 2'd1;
    localparam logic [1:0] ST_BAD_ADDR = 2'd2;

    localparam logic [7:0] ADDR_LIMIT        = 8'h7f;
    localparam logic [7:0] HALF_PERIOD_RESET = 8'd5;
    localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

    // Bus sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START     = 4'd1,
        PH_TX_LOW    = 4'd2,
        PH_TX_HIGH   = 4'd3,
        PH_TXA_LOW   = 4'd4,
        PH_TXA_HIGH  = 4'd5,
        PH_RX_LOW    = 4'd6,
        PH_RX_HIGH   = 4'd7,
        PH_RXA_LOW   = 4'd8,
        PH_RXA_HIGH  = 4'd9,
        PH_RS_LOW    = 4'd10,
        PH_RS_HIGH   = 4'd11,
        PH_RS_HOLD   = 4'd12,
        PH_STOP_LOW  = 4'd13,
        PH_STOP_HIGH = 4'd14
    } phase_t;

    // One input word
    typedef struct packed {
        logic [1:0] func;
        logic       sda_in;
        logic       scl_in;
        logic [7:0] data_byte;
        logic [7:0] target_address;
        logic [7:0] read_count;
    } item_t;

    // One result word
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       read_valid;
        logic [7:0] read_data;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
    } result_t;

    // Sequencer to write FIFO
    typedef struct packed {
        logic       push;
        logic [7:0] push_data;
        logic       pop;
        logic       clear;
    } fifo_ctrl_t;

    // Write FIFO to sequencer
    typedef struct packed {
        logic       empty;
        logic       full;
        logic [7:0] head_data;
    } fifo_stat_t;

endpackage

/* design/i2c_master_transfer.sv */
`timescale 1ns / 1ps

// I2C master transfer: one word in, one result word out, one word per clock sustained
// while the result side does not stall. Each word passes an input register and the bus
// sequencer into the output register; both registers keep moving while the result side
// stalls only if the output register is empty. Tick words advance the half-period timer
// (half_period_reg ticks, at least one, per SCL half period; a low SCL on a released
// phase holds the timer); push words fill a WRITE_DEPTH-entry write FIFO while idle; a
// begin word with an address up to ADDR_LIMIT starts START, address, writes, repeated
// START, reads and STOP. scl_out and sda_out are open-drain levels (1 released). Write
// cfg_wr_data only while idle.
module i2c_master_transfer #(
    parameter int WRITE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  i2cm_pkg::item_t   in_word,
    output logic              out_valid,
    input  logic              out_stall,
    output i2cm_pkg::result_t out_word,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data
);
    import i2cm_pkg::*;

    logic       in_valid_reg;
    item_t      in_word_reg;
    logic       out_valid_reg;
    result_t    out_word_reg;
    logic [7:0] half_period_reg;
    logic       go;
    logic       in_take;
    result_t    step_res;
    fifo_ctrl_t fifo_ctrl;
    fifo_stat_t fifo_stat;

    // Process the held word whenever the output register can take the result
    assign go       = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !go;
    assign in_take  = in_valid && !in_stall;

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            half_period_reg <= cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (go)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_word_reg <= in_word;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            out_word_reg <= step_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    i2cm_sequencer u_sequencer (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .item        (in_word_reg),
        .half_period (half_period_reg),
        .fifo_stat   (fifo_stat),
        .fifo_ctrl   (fifo_ctrl),
        .res         (step_res)
    );

    i2cm_write_fifo #(
        .DEPTH (WRITE_DEPTH)
    ) u_write_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (fifo_ctrl),
        .stat  (fifo_stat)
    );

endmodule

/* design/i2cm_write_fifo.sv */
`timescale 1ns / 1ps

module i2cm_write_fifo #(
    parameter int DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  i2cm_pkg::fifo_ctrl_t ctrl,
    output i2cm_pkg::fifo_stat_t stat
);
    import i2cm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic [7:0]    head_data_reg;
    logic [FW:0]   tail_sum;
    logic [FW:0]   tail_wrap;
    logic [AW-1:0] tail_addr;
    logic [AW-1:0] head_inc;

    // Locate the tail slot, wrapping once past the end
    always_comb
    begin
        tail_sum  = (FW + 1)'(head_reg) + (FW + 1)'(fill_reg);
        tail_wrap = (tail_sum >= (FW + 1)'(DEPTH)) ? tail_sum - (FW + 1)'(DEPTH) : tail_sum;
        tail_addr = tail_wrap[AW-1:0];
        head_inc  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    end

    // Advance pointers; drop everything on clear
    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (ctrl.clear)
        begin
            fill_next = '0;
        end
        else if (ctrl.pop)
        begin
            head_next = head_inc;
            fill_next = fill_reg - FW'(1);
        end
        else if (ctrl.push)
        begin
            fill_next = fill_reg + FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_addr] <= ctrl.push_data;
        end
    end

    // Keep the word at the next head ready, passing a same-cycle write through
    always_ff @(posedge clk)
    begin
        if (ctrl.push && (tail_addr == head_next))
        begin
            head_data_reg <= ctrl.push_data;
        end
        else
        begin
            head_data_reg <= mem[head_next];
        end
    end

    assign stat.empty     = (fill_reg == '0);
    assign stat.full      = (fill_reg == FW'(DEPTH));
    assign stat.head_data = head_data_reg;

endmodule

/* design/i2cm_sequencer.sv */
`timescale 1ns / 1ps
`include "i2c_master_transfer_defines.svh"

module i2cm_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  i2cm_pkg::item_t      item,
    input  logic [7:0]           half_period,
    input  i2cm_pkg::fifo_stat_t fifo_stat,
    output i2cm_pkg::fifo_ctrl_t fifo_ctrl,
    output i2cm_pkg::result_t    res
);
    import i2cm_pkg::*;

    phase_t     phase_reg,      phase_next;
    logic [7:0] timer_reg,      timer_next;
    logic [3:0] bit_reg,        bit_next;
    logic [7:0] shift_reg,      shift_next;
    logic [7:0] reads_left_reg, reads_left_next;
    logic [6:0] addr_reg,       addr_next;
    logic       scl_reg,        scl_next;
    logic       sda_reg,        sda_next;
    logic [1:0] status_reg,     status_next;
    logic       addr_read_reg,  addr_read_next;

    logic       enter_en;
    phase_t     enter_ph;
    logic       stretched;
    logic       half_done;
    logic [8:0] timer_inc;
    logic [7:0] reads_dec;
    logic [3:0] bit_inc;
    logic       rvalid;
    logic [7:0] rdata;
    logic       done;
    logic [1:0] stat;

    assign timer_inc = {1'b0, timer_reg} + 9'd1;
    assign half_done = (timer_inc >= {1'b0, half_period});
    assign stretched = scl_reg && !item.scl_in;
    assign reads_dec = (reads_left_reg == '0) ? '0 : reads_left_reg - 8'd1;
    assign bit_inc   = bit_reg + 4'd1;

    // Step the bus sequencer by one word
    always_comb
    begin
        phase_next      = phase_reg;
        timer_next      = timer_reg;
        bit_next        = bit_reg;
        shift_next      = shift_reg;
        reads_left_next = reads_left_reg;
        addr_next       = addr_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        status_next     = status_reg;
        addr_read_next  = addr_read_reg;
        enter_en        = 1'b0;
        enter_ph        = PH_IDLE;
        rvalid          = 1'b0;
        rdata           = '0;
        done            = 1'b0;
        stat            = ST_OK;
        fifo_ctrl       = '0;
        fifo_ctrl.push_data = item.data_byte;

        if (go)
        begin
            unique case (item.func)
                FUNC_PUSH:
                begin
                    fifo_ctrl.push = (phase_reg == PH_IDLE) && !fifo_stat.full;
                end
                FUNC_BEGIN:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        if (item.target_address > ADDR_LIMIT)
                        begin
                            status_next = ST_BAD_ADDR;
                            done        = 1'b1;
                            stat        = ST_BAD_ADDR;
                        end
                        else
                        begin
                            addr_next       = item.target_address[6:0];
                            reads_left_next = item.read_count;
                            status_next     = ST_OK;
                            bit_next        = '0;
                            if (!fifo_stat.empty || (item.read_count == '0))
                            begin
                                shift_next     = {item.target_address[6:0], 1'b0};
                                addr_read_next = 1'b0;
                            end
                            else
                            begin
                                shift_next     = {item.target_address[6:0], 1'b1};
                                addr_read_next = 1'b1;
                            end
                            enter_en = 1'b1;
                            enter_ph = PH_START;
                        end
                    end
                end
                FUNC_TICK:
                begin
                    if ((phase_reg != PH_IDLE) && !stretched)
                    begin
                        if (!half_done)
                        begin
                            timer_next = timer_inc[7:0];
                        end
                        else
                        begin
                            enter_en = 1'b1;
                            unique case (phase_reg)
                                PH_START:    enter_ph = PH_TX_LOW;
                                PH_TX_LOW:   enter_ph = PH_TX_HIGH;
                                PH_TX_HIGH:
                                begin
                                    shift_next = {shift_reg[6:0], 1'b0};
                                    bit_next   = bit_inc;
                                    enter_ph   = (bit_inc >= BITS_PER_BYTE) ? PH_TXA_LOW
                                                                            : PH_TX_LOW;
                                end
                                PH_TXA_LOW:  enter_ph = PH_TXA_HIGH;
                                PH_TXA_HIGH:
                                begin
                                    if (item.sda_in)
                                    begin
                                        // Target refused: drop queued words and stop
                                        status_next     = ST_NACK;
                                        fifo_ctrl.clear = 1'b1;
                                        enter_ph        = PH_STOP_LOW;
                                    end
                                    else
                                    begin
                                        bit_next = '0;
                                        if (addr_read_reg)
                                        begin
                                            shift_next = '0;
                                            enter_ph   = PH_RX_LOW;
                                        end
                                        else if (!fifo_stat.empty)
                                        begin
                                            shift_next    = fifo_stat.head_data;
                                            fifo_ctrl.pop = 1'b1;
                                            enter_ph      = PH_TX_LOW;
                                        end
                                        else if (reads_left_reg != '0)
                                        begin
                                            enter_ph = PH_RS_LOW;
                                        end
                                        else
                                        begin
                                            enter_ph = PH_STOP_LOW;
                                        end
                                    end
                                end
                                PH_RX_LOW:   enter_ph = PH_RX_HIGH;
                                PH_RX_HIGH:
                                begin
                                    shift_next = {shift_reg[6:0], item.sda_in};
                                    bit_next   = bit_inc;
                                    if (bit_inc >= BITS_PER_BYTE)
                                    begin
                                        rvalid   = 1'b1;
                                        rdata    = {shift_reg[6:0], item.sda_in};
                                        enter_ph = PH_RXA_LOW;
                                    end
                                    else
                                    begin
                                        enter_ph = PH_RX_LOW;
                                    end
                                end
                                PH_RXA_LOW:  enter_ph = PH_RXA_HIGH;
                                PH_RXA_HIGH:
                                begin
                                    reads_left_next = reads_dec;
                                    if (reads_dec != '0)
                                    begin
                                        bit_next   = '0;
                                        shift_next = '0;
                                        enter_ph   = PH_RX_LOW;
                                    end
                                    else
                                    begin
                                        enter_ph = PH_STOP_LOW;
                                    end
                                end
                                PH_RS_LOW:   enter_ph = PH_RS_HIGH;
                                PH_RS_HIGH:  enter_ph = PH_RS_HOLD;
                                PH_RS_HOLD:
                                begin
                                    shift_next     = {addr_reg, 1'b1};
                                    addr_read_next = 1'b1;
                                    bit_next       = '0;
                                    enter_ph       = PH_TX_LOW;
                                end
                                PH_STOP_LOW: enter_ph = PH_STOP_HIGH;
                                default:
                                begin
                                    enter_ph = PH_IDLE;
                                    done     = 1'b1;
                                    stat     = status_reg;
                                end
                            endcase
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Enter a new phase: restart the timer and set the line drives
        if (enter_en)
        begin
            phase_next = enter_ph;
            timer_next = '0;
            unique case (enter_ph)
                PH_START:     begin scl_next = 1'b1; sda_next = 1'b0;          end
                PH_TX_LOW:    begin scl_next = 1'b0; sda_next = shift_next[7]; end
                PH_TX_HIGH:   begin scl_next = 1'b1;                           end
                PH_TXA_LOW:   begin scl_next = 1'b0; sda_next = 1'b1;          end
                PH_TXA_HIGH:  begin scl_next = 1'b1; sda_next = 1'b1;          end
                PH_RX_LOW:    begin scl_next = 1'b0; sda_next = 1'b1;          end
                PH_RX_HIGH:   begin scl_next = 1'b1; sda_next = 1'b1;          end
                PH_RXA_LOW:
                begin
                    scl_next = 1'b0;
                    sda_next = (reads_left_next <= 8'd1);
                end
                PH_RXA_HIGH:  begin scl_next = 1'b1;                           end
                PH_RS_LOW:    begin scl_next = 1'b0; sda_next = 1'b1;          end
                PH_RS_HIGH:   begin scl_next = 1'b1; sda_next = 1'b1;          end
                PH_RS_HOLD:   begin scl_next = 1'b1; sda_next = 1'b0;          end
                PH_STOP_LOW:  begin scl_next = 1'b0; sda_next = 1'b0;          end
                PH_STOP_HIGH: begin scl_next = 1'b1; sda_next = 1'b0;          end
                default:      begin scl_next = 1'b1; sda_next = 1'b1;          end
            endcase
        end
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            timer_reg      <= '0;
            bit_reg        <= '0;
            shift_reg      <= '0;
            reads_left_reg <= '0;
            addr_reg       <= '0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            status_reg     <= ST_OK;
            addr_read_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            timer_reg      <= timer_next;
            bit_reg        <= bit_next;
            shift_reg      <= shift_next;
            reads_left_reg <= reads_left_next;
            addr_reg       <= addr_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            status_reg     <= status_next;
            addr_read_reg  <= addr_read_next;
        end
    end

    // Result word for this step
    always_comb
    begin
        res.scl_out    = scl_next;
        res.sda_out    = sda_next;
        res.read_valid = rvalid;
        res.read_data  = rdata;
        res.busy_res   = (phase_next != PH_IDLE);
        res.done_res   = done;
        res.status     = stat;
    end

    `I2CM_ASSERT(a_done_goes_idle, go && res.done_res |-> phase_next == PH_IDLE)
    `I2CM_ASSERT(a_read_from_rx_high, go && res.read_valid |-> phase_reg == PH_RX_HIGH)
    `I2CM_NEVER(a_no_pop_when_idle, fifo_ctrl.pop && (phase_reg == PH_IDLE))
    `I2CM_NEVER(a_bit_count_range, bit_reg > BITS_PER_BYTE)

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import i2cm_pkg::*;

    localparam int FIFO_DEPTH = 16;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int REPORT_MAX = 10;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    // Bus sequencer predictor plus the queue of result words it has produced
    class i2c_scoreboard;
        logic [7:0] half_ticks;
        phase_t     bus_phase;
        logic [7:0] half_timer;
        logic [3:0] bit_cnt;
        logic [7:0] shifter;
        logic [7:0] fifo_mem [FIFO_DEPTH];
        logic [4:0] fill;
        logic [3:0] head;
        logic [7:0] reads_left;
        logic [6:0] addr_saved;
        logic       scl_drv;
        logic       sda_drv;
        logic [1:0] end_status;
        logic       addr_is_read;
        result_t    expected_q[$];
        int         mismatches;
        int         checked;

        function new();
            half_ticks   = HALF_PERIOD_RESET;
            bus_phase    = PH_IDLE;
            half_timer   = '0;
            bit_cnt      = '0;
            shifter      = '0;
            fill         = '0;
            head         = '0;
            reads_left   = '0;
            addr_saved   = '0;
            scl_drv      = 1'b1;
            sda_drv      = 1'b1;
            end_status   = ST_OK;
            addr_is_read = 1'b0;
            mismatches   = 0;
            checked      = 0;
            foreach (fifo_mem[i])
                fifo_mem[i] = '0;
        endfunction

        // Move to a phase and set the pin drive levels that go with it
        function void enter_phase(phase_t p);
            bus_phase  = p;
            half_timer = '0;
            case (p)
                PH_START:     begin scl_drv = 1'b1; sda_drv = 1'b0; end
                PH_TX_LOW:    begin scl_drv = 1'b0; sda_drv = shifter[7]; end
                PH_TX_HIGH:   scl_drv = 1'b1;
                PH_TXA_LOW:   begin scl_drv = 1'b0; sda_drv = 1'b1; end
                PH_TXA_HIGH:  begin scl_drv = 1'b1; sda_drv = 1'b1; end
                PH_RX_LOW:    begin scl_drv = 1'b0; sda_drv = 1'b1; end
                PH_RX_HIGH:   begin scl_drv = 1'b1; sda_drv = 1'b1; end
                PH_RXA_LOW:   begin scl_drv = 1'b0; sda_drv = (reads_left <= 8'd1); end
                PH_RXA_HIGH:  scl_drv = 1'b1;
                PH_RS_LOW:    begin scl_drv = 1'b0; sda_drv = 1'b1; end
                PH_RS_HIGH:   begin scl_drv = 1'b1; sda_drv = 1'b1; end
                PH_RS_HOLD:   begin scl_drv = 1'b1; sda_drv = 1'b0; end
                PH_STOP_LOW:  begin scl_drv = 1'b0; sda_drv = 1'b0; end
                PH_STOP_HIGH: begin scl_drv = 1'b1; sda_drv = 1'b0; end
                default:
                begin
                    bus_phase = PH_IDLE;
                    scl_drv   = 1'b1;
                    sda_drv   = 1'b1;
                end
            endcase
        endfunction

        // Apply one accepted word; return 1 when the block acts on it
        function bit note_word(item_t w);
            result_t    r;
            logic [8:0] t;
            logic [3:0] slot;
            bit         live;
            r    = '0;
            live = 1'b0;
            case (w.func)
                FUNC_PUSH:
                begin
                    if (bus_phase == PH_IDLE && fill < 5'(FIFO_DEPTH))
                    begin
                        slot = head + fill[3:0];
                        fifo_mem[slot] = w.data_byte;
                        fill = fill + 5'd1;
                        live = 1'b1;
                    end
                end
                FUNC_BEGIN:
                begin
                    if (bus_phase == PH_IDLE)
                    begin
                        live = 1'b1;
                        if (w.target_address > ADDR_LIMIT)
                        begin
                            end_status = ST_BAD_ADDR;
                            r.done_res = 1'b1;
                            r.status   = ST_BAD_ADDR;
                        end
                        else
                        begin
                            addr_saved = w.target_address[6:0];
                            reads_left = w.read_count;
                            end_status = ST_OK;
                            bit_cnt    = '0;
                            // write direction first unless this is a pure read
                            if (fill > 0 || w.read_count == 8'd0)
                            begin
                                shifter      = {addr_saved, 1'b0};
                                addr_is_read = 1'b0;
                            end
                            else
                            begin
                                shifter      = {addr_saved, 1'b1};
                                addr_is_read = 1'b1;
                            end
                            enter_phase(PH_START);
                        end
                    end
                end
                FUNC_TICK:
                begin
                    if (bus_phase != PH_IDLE)
                    begin
                        live = 1'b1;
                        // hold the timer while a target stretches a released SCL
                        if (!(scl_drv && !w.scl_in))
                        begin
                            t = {1'b0, half_timer} + 9'd1;
                            if (t < {1'b0, half_ticks})
                                half_timer = t[7:0];
                            else
                            begin
                                case (bus_phase)
                                    PH_START:    enter_phase(PH_TX_LOW);
                                    PH_TX_LOW:   enter_phase(PH_TX_HIGH);
                                    PH_TX_HIGH:
                                    begin
                                        shifter = shifter << 1;
                                        bit_cnt = bit_cnt + 4'd1;
                                        if (bit_cnt >= BITS_PER_BYTE)
                                            enter_phase(PH_TXA_LOW);
                                        else
                                            enter_phase(PH_TX_LOW);
                                    end
                                    PH_TXA_LOW:  enter_phase(PH_TXA_HIGH);
                                    PH_TXA_HIGH:
                                    begin
                                        bit_cnt = '0;
                                        if (w.sda_in)
                                        begin
                                            // no acknowledge: drop the rest and stop
                                            end_status = ST_NACK;
                                            fill       = '0;
                                            enter_phase(PH_STOP_LOW);
                                        end
                                        else if (addr_is_read)
                                        begin
                                            shifter = '0;
                                            enter_phase(PH_RX_LOW);
                                        end
                                        else if (fill > 0)
                                        begin
                                            shifter = fifo_mem[head];
                                            head    = head + 4'd1;
                                            fill    = fill - 5'd1;
                                            enter_phase(PH_TX_LOW);
                                        end
                                        else if (reads_left > 0)
                                            enter_phase(PH_RS_LOW);
                                        else
                                            enter_phase(PH_STOP_LOW);
                                    end
                                    PH_RX_LOW:   enter_phase(PH_RX_HIGH);
                                    PH_RX_HIGH:
                                    begin
                                        shifter = {shifter[6:0], w.sda_in};
                                        bit_cnt = bit_cnt + 4'd1;
                                        if (bit_cnt >= BITS_PER_BYTE)
                                        begin
                                            r.read_valid = 1'b1;
                                            r.read_data  = shifter;
                                            enter_phase(PH_RXA_LOW);
                                        end
                                        else
                                            enter_phase(PH_RX_LOW);
                                    end
                                    PH_RXA_LOW:  enter_phase(PH_RXA_HIGH);
                                    PH_RXA_HIGH:
                                    begin
                                        if (reads_left > 0)
                                            reads_left = reads_left - 8'd1;
                                        if (reads_left > 0)
                                        begin
                                            bit_cnt = '0;
                                            shifter = '0;
                                            enter_phase(PH_RX_LOW);
                                        end
                                        else
                                            enter_phase(PH_STOP_LOW);
                                    end
                                    PH_RS_LOW:   enter_phase(PH_RS_HIGH);
                                    PH_RS_HIGH:  enter_phase(PH_RS_HOLD);
                                    PH_RS_HOLD:
                                    begin
                                        shifter      = {addr_saved, 1'b1};
                                        addr_is_read = 1'b1;
                                        bit_cnt      = '0;
                                        enter_phase(PH_TX_LOW);
                                    end
                                    PH_STOP_LOW: enter_phase(PH_STOP_HIGH);
                                    default:
                                    begin
                                        enter_phase(PH_IDLE);
                                        r.done_res = 1'b1;
                                        r.status   = end_status;
                                    end
                                endcase
                            end
                        end
                    end
                end
                default: ;
            endcase
            r.scl_out  = scl_drv;
            r.sda_out  = sda_drv;
            r.busy_res = (bus_phase != PH_IDLE);
            expected_q.push_back(r);
            return live;
        endfunction

        // Compare one accepted result word with the oldest prediction
        function void check_result(result_t got);
            result_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result %0d arrived with nothing predicted: %h", checked, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
                got.read_valid !== want.read_valid || got.read_data !== want.read_data ||
                got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
                got.status !== want.status)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"result %0d: expected scl=%b sda=%b rv=%b rd=%h busy=%b ",
                              "done=%b st=%0d, got scl=%b sda=%b rv=%b rd=%h busy=%b ",
                              "done=%b st=%0d"}, checked,
                             want.scl_out, want.sda_out, want.read_valid, want.read_data,
                             want.busy_res, want.done_res, want.status,
                             got.scl_out, got.sda_out, got.read_valid, got.read_data,
                             got.busy_res, got.done_res, got.status);
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    item_t      in_word = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    result_t    out_word;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = '0;

    i2c_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int ack_pct = 90;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int idle_cycles = 0;
    int pushes_planned = 2;
    int pushes_done = 0;

    i2c_master_transfer #(
        .WRITE_DEPTH(FIFO_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Drive result-side stall: random, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Check every accepted result word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_word);
    end

    // Abort when no word moves on either side for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    function automatic item_t make_word(logic [1:0] f, logic sda, logic scl,
                                        logic [7:0] data, logic [7:0] addr,
                                        logic [7:0] count);
        item_t w;
        w.func           = f;
        w.sda_in         = sda;
        w.scl_in         = scl;
        w.data_byte      = data;
        w.target_address = addr;
        w.read_count     = count;
        return w;
    endfunction

    function automatic item_t random_word();
        return make_word(2'($urandom_range(3)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 8'($urandom_range(255)));
    endfunction

    // Tick from a responsive target: ACK with ack_pct percent odds, occasional clock stretch
    function automatic item_t tick_word();
        item_t w;
        w        = random_word();
        w.func   = FUNC_TICK;
        w.scl_in = ($urandom_range(99) >= 10);
        if (sb.bus_phase == PH_TXA_HIGH)
            w.sda_in = ($urandom_range(99) >= ack_pct);
        return w;
    endfunction

    // Choose the next word: mostly well-formed transfers, some noise
    function automatic item_t pick_word();
        item_t w;
        int    r;
        bit    slow;
        slow = (sb.half_ticks > 8'd8);
        r    = $urandom_range(99);
        w    = random_word();
        if (sb.bus_phase != PH_IDLE)
        begin
            if (r >= 8)
                return tick_word();
            // pushes, begins and dead codes while busy are ignored
            case ($urandom_range(2))
                0:       w.func = FUNC_PUSH;
                1:       w.func = FUNC_BEGIN;
                default: w.func = FUNC_NONE;
            endcase
            return w;
        end
        if (r < 6)
        begin
            w.func = $urandom_range(1) ? FUNC_NONE : FUNC_TICK;
            return w;
        end
        if (pushes_done < pushes_planned)
        begin
            w.func = FUNC_PUSH;
            pushes_done++;
            return w;
        end
        w.func = FUNC_BEGIN;
        if ($urandom_range(99) < 8)
            w.target_address = 8'($urandom_range(255, 128));
        else
            w.target_address = 8'($urandom_range(127));
        r = $urandom_range(99);
        if (slow)
            w.read_count = 8'($urandom_range(1));
        else if (r < 35)
            w.read_count = '0;
        else if (r < 85)
            w.read_count = 8'($urandom_range(3, 1));
        else if (r < 97 || sb.half_ticks > 8'd3)
            w.read_count = 8'($urandom_range(10, 4));
        else
            w.read_count = 8'($urandom_range(255, 11));
        // plan the FIFO fill for the next transfer
        r = $urandom_range(99);
        if (slow)
            pushes_planned = $urandom_range(1);
        else if (r < 70)
            pushes_planned = $urandom_range(3);
        else if (r < 95)
            pushes_planned = $urandom_range(12, 4);
        else
            pushes_planned = $urandom_range(18, 15);
        pushes_done = 0;
        return w;
    endfunction

    // Offer one word and hold it until the block takes it
    task automatic send_word(input item_t w, output bit live);
        in_word  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        live = sb.note_word(w);
    endtask

    task automatic sender_pause();
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Tick until the bus sequencer is back to idle
    task automatic finish_transfer();
        bit live;
        while (sb.bus_phase != PH_IDLE)
        begin
            sender_pause();
            send_word(tick_word(), live);
        end
    endtask

    // Stop offering and wait until every predicted result has arrived
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.expected_q.size() != 0);
        @(posedge clk);
    endtask

    task automatic set_half_period(input logic [7:0] ticks);
        finish_transfer();
        drain_results();
        cfg_wr_data <= ticks;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        sb.half_ticks  = ticks;
    endtask

    task automatic run_items(input int count, input int send_pct, input int recv_pct,
                             input int hold_at);
        int n;
        bit live;
        n              = 0;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (n < count)
        begin
            if (n == hold_at)
                hold_request = 1'b1;
            sender_pause();
            send_word(pick_word(), live);
            if (live)
                n++;
        end
    endtask

    task automatic run_directed();
        bit live;
        send_word(make_word(FUNC_NONE, 1'b1, 1'b1, 8'hff, 8'hff, 8'hff), live);
        send_word(make_word(FUNC_TICK, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00), live);
        send_word(make_word(FUNC_PUSH, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00), live);
        send_word(make_word(FUNC_PUSH, 1'b1, 1'b1, 8'hff, 8'h00, 8'h00), live);
        // rejected addresses leave the FIFO alone
        send_word(make_word(FUNC_BEGIN, 1'b0, 1'b1, 8'h00, 8'h80, 8'h00), live);
        send_word(make_word(FUNC_BEGIN, 1'b1, 1'b1, 8'h00, 8'hff, 8'hff), live);
        // writes, repeated start and one read
        send_word(make_word(FUNC_BEGIN, 1'b0, 1'b1, 8'h00, 8'h7f, 8'h01), live);
        send_word(make_word(FUNC_PUSH, 1'b0, 1'b1, 8'ha5, 8'h00, 8'h00), live);
        send_word(make_word(FUNC_BEGIN, 1'b0, 1'b1, 8'h00, 8'h10, 8'h02), live);
        send_word(make_word(FUNC_NONE, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00), live);
        finish_transfer();
        // address-only probe
        send_word(make_word(FUNC_BEGIN, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00), live);
        finish_transfer();
        // target refuses the address; queued byte is dropped
        ack_pct = 0;
        send_word(make_word(FUNC_PUSH, 1'b0, 1'b1, 8'h3c, 8'h00, 8'h00), live);
        send_word(make_word(FUNC_BEGIN, 1'b0, 1'b1, 8'h00, 8'h22, 8'h00), live);
        finish_transfer();
        ack_pct = 100;
        // longest read with no write phase
        send_word(make_word(FUNC_BEGIN, 1'b0, 1'b1, 8'h00, 8'h55, 8'hff), live);
        finish_transfer();
        ack_pct = 90;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        set_half_period(8'd1);
        run_items(400, 0, 0, -1);
        set_half_period(8'd2);
        run_items(350, 79, 0, -1);
        set_half_period(8'd255);
        run_items(300, 0, 79, -1);
        set_half_period(8'd3);
        run_items(400, 32, 32, 100);
        set_half_period(8'd0);
        run_items(200, 0, 0, -1);
        set_half_period(8'd5);
        run_items(200, 79, 79, -1);

        finish_transfer();
        drain_results();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
